// ===== src/pixel_to_hex_grid_coord_assert.svh =====
// Assertion macros for the pixel to hex grid coordinate block
`ifndef PIXEL_TO_HEX_GRID_COORD_ASSERT_SVH
`define PIXEL_TO_HEX_GRID_COORD_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst
`define P2HG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst
`define P2HG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/p2hg_pkg.sv =====
// Package: widths and register codes of the hex grid lookup
`timescale 1ns / 1ps
package p2hg_pkg;
  localparam int COORD_W    = 12;
  localparam int RAD_W      = 10;
  localparam int CNT_W      = 9;
  localparam int OUT_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int DEN_W = 21;   // 2*h*r
  localparam int MAG_W = 25;   // magnitude of a dividend
  localparam int QW    = 13;   // quotient bits per divide

  localparam int DIV3_OFS = 12288;  // 3*4096, keeps the divide-by-3 input positive
  localparam int DIV3_MUL = 21846;  // ceil(2^16/3)

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HGT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd5;
endpackage

// ===== src/p2hg_if.sv =====
// Interfaces: pixel request channel and hex result channel
`timescale 1ns / 1ps
interface p2hg_in_if;
  logic valid;
  logic ready;
  logic [p2hg_pkg::COORD_W-1:0] pixel_x;
  logic [p2hg_pkg::COORD_W-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface p2hg_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [p2hg_pkg::OUT_W-1:0] hex_row;
  logic signed [p2hg_pkg::OUT_W-1:0] hex_col;
  modport source (output valid, output hit, output hex_row, output hex_col, input ready);
  modport sink   (input valid, input hit, input hex_row, input hex_col, output ready);
endinterface

// ===== src/pixel_to_hex_grid_coord.sv =====
// Top level: pixel position to flat-top odd-q hexagon (row, col), 18 stage pipeline
// Result: taken from the stage 18 result register and held on res while res.ready is low.
// Throughput: one request per cycle while res.ready is high; the cost is set by two 13-step restoring
//   dividers by 2*h*r and one by h, one quotient bit per pipeline stage.
// Reset (rst, synchronous): pipeline empties, configuration registers return to their defaults.
`timescale 1ns / 1ps
`include "pixel_to_hex_grid_coord_assert.svh"
module pixel_to_hex_grid_coord #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [p2hg_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [p2hg_pkg::CFG_DATA_W-1:0]    wr_data,
  p2hg_in_if.sink                            pix,
  p2hg_out_if.source                         res
);
  import p2hg_pkg::*;

  localparam int NS = 18;        // pipeline depth
  localparam int DIV_FIRST = 4;  // first divide stage
  localparam int DIV_LAST  = 16; // last divide stage
  localparam logic [12:0] MAX_ROWS_L = 13'(MAX_ROWS);
  localparam logic [12:0] MAX_COLS_L = 13'(MAX_COLS);

  // ---------------- configuration registers ----------------
  logic [COORD_W-1:0] origin_x, origin_y;
  logic [RAD_W-1:0]   hex_radius, hex_half_height;
  logic [CNT_W-1:0]   grid_rows, grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_y        <= '0;
      hex_radius      <= 10'd32;
      hex_half_height <= 10'd27;
      grid_rows       <= '0;
      grid_cols       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_X:  origin_x        <= wr_data;
        REG_ORIGIN_Y:  origin_y        <= wr_data;
        REG_RADIUS:    hex_radius      <= wr_data[RAD_W-1:0];
        REG_HALF_HGT:  hex_half_height <= wr_data[RAD_W-1:0];
        REG_GRID_ROWS: grid_rows       <= wr_data[CNT_W-1:0];
        REG_GRID_COLS: grid_cols       <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The user must change registers only while the pipe is empty (not enforced here), so stages read them directly.
  logic [CNT_W-1:0] rows_eff, cols_eff;
  assign rows_eff = ({4'b0, grid_rows} > MAX_ROWS_L) ? MAX_ROWS_L[CNT_W-1:0] : grid_rows;
  assign cols_eff = ({4'b0, grid_cols} > MAX_COLS_L) ? MAX_COLS_L[CNT_W-1:0] : grid_cols;

  // ---------------- flow control ----------------
  // v[i]: stage i holds a request. en[i]: stage i loads this cycle.
  logic v  [1:NS];
  logic en [1:NS+1];

  always_comb begin
    en[NS+1] = res.ready;
    for (int i = NS; i >= 1; i--) en[i] = !v[i] || en[i+1];
  end
  assign pix.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NS; i++) v[i] <= 1'b0;
    end else begin
      if (en[1]) v[1] <= pix.valid;
      for (int i = 2; i <= NS; i++) if (en[i]) v[i] <= v[i-1];
    end
  end

  // ---------------- stage 1: remove origin ----------------
  logic signed [COORD_W:0] x1, y1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= $signed({1'b0, pix.pixel_x}) - $signed({1'b0, origin_x});
      y1 <= $signed({1'b0, pix.pixel_y}) - $signed({1'b0, origin_y});
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [COORD_W+1:0] ymh1;     // y - h
  logic [19:0]               hr1;      // h*r
  logic [RAD_W:0]            cols3;    // 3*cols+1
  logic [RAD_W-1:0]          rows2;    // 2*rows + (cols>0)
  assign ymh1  = $signed({y1[COORD_W], y1}) - $signed({4'b0, hex_half_height});
  assign hr1   = hex_half_height * hex_radius;
  assign cols3 = (RAD_W+1)'(3 * cols_eff + 1);
  assign rows2 = {rows_eff, 1'b0} | RAD_W'(cols_eff != '0);

  logic signed [COORD_W:0] x2, y2;
  logic signed [24:0]      yhr2;    // (y-h)*r
  logic signed [23:0]      hx2;     // h*x
  logic [20:0]             wprod2;  // r*(3*cols+1)
  logic [19:0]             hprod2;  // height
  logic [DEN_W-1:0]        den;

  assign den = {hr1, 1'b0};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2     <= x1;
      y2     <= y1;
      yhr2   <= ymh1 * $signed({1'b0, hex_radius});
      hx2    <= x1 * $signed({1'b0, hex_half_height});
      wprod2 <= (cols_eff == '0) ? 21'd0 : hex_radius * cols3;
      hprod2 <= hex_half_height * rows2;
    end
  end

  // ---------------- stage 3: dividends, bounds ----------------
  logic signed [25:0] n1, n2;
  logic               hit2;
  assign n1 = $signed({hx2[23], hx2, 1'b0}) + 26'(yhr2);
  assign n2 = $signed({hx2[23], hx2, 1'b0}) - 26'(yhr2);
  assign hit2 = (hex_radius != '0) && (hex_half_height != '0) &&
                !x2[COORD_W] && !y2[COORD_W] &&
                ({8'b0, x2[COORD_W-1:0]} < wprod2[20:1]) &&
                ({8'b0, y2[COORD_W-1:0]} < hprod2);

  // Divide pipeline, indexed by stage; index 3 is the loaded value.
  // Negative dividends: floor(n/d) = ~((~n)/d), so only magnitudes are divided.
  logic [MAG_W-1:0]   rm1 [3:DIV_LAST];
  logic [MAG_W-1:0]   rm2 [3:DIV_LAST];
  logic [COORD_W-1:0] rmy [3:DIV_LAST];
  logic [QW-1:0]      q1  [3:DIV_LAST];
  logic [QW-1:0]      q2  [3:DIV_LAST];
  logic [QW-1:0]      qy  [3:DIV_LAST];
  logic               sg1 [3:DIV_LAST];
  logic               sg2 [3:DIV_LAST];
  logic               ht  [3:DIV_LAST];

  logic [34:0]        tr1 [DIV_FIRST:DIV_LAST];
  logic [34:0]        tr2 [DIV_FIRST:DIV_LAST];
  logic [22:0]        try [DIV_FIRST:DIV_LAST];
  logic [QW-1:0]      qn1 [DIV_FIRST:DIV_LAST];
  logic [QW-1:0]      qn2 [DIV_FIRST:DIV_LAST];
  logic [QW-1:0]      qny [DIV_FIRST:DIV_LAST];

  always_comb begin
    for (int i = DIV_FIRST; i <= DIV_LAST; i++) begin
      tr1[i] = {10'b0, rm1[i-1]} - ({14'b0, den} << (DIV_LAST - i));
      tr2[i] = {10'b0, rm2[i-1]} - ({14'b0, den} << (DIV_LAST - i));
      try[i] = {11'b0, rmy[i-1]} - ({13'b0, hex_half_height} << (DIV_LAST - i));
      qn1[i] = q1[i-1];
      qn2[i] = q2[i-1];
      qny[i] = qy[i-1];
      qn1[i][DIV_LAST - i] = !tr1[i][34];
      qn2[i][DIV_LAST - i] = !tr2[i][34];
      qny[i][DIV_LAST - i] = !try[i][22];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rm1[3] <= n1[25] ? ~n1[MAG_W-1:0] : n1[MAG_W-1:0];
      rm2[3] <= n2[25] ? ~n2[MAG_W-1:0] : n2[MAG_W-1:0];
      rmy[3] <= y2[COORD_W-1:0];
      q1[3]  <= '0;
      q2[3]  <= '0;
      qy[3]  <= '0;
      sg1[3] <= n1[25];
      sg2[3] <= n2[25];
      ht[3]  <= hit2;
    end
    for (int i = DIV_FIRST; i <= DIV_LAST; i++) begin
      if (en[i]) begin
        rm1[i] <= tr1[i][34] ? rm1[i-1] : tr1[i][MAG_W-1:0];
        rm2[i] <= tr2[i][34] ? rm2[i-1] : tr2[i][MAG_W-1:0];
        rmy[i] <= try[i][22] ? rmy[i-1] : try[i][COORD_W-1:0];
        q1[i]  <= qn1[i];
        q2[i]  <= qn2[i];
        qy[i]  <= qny[i];
        sg1[i] <= sg1[i-1];
        sg2[i] <= sg2[i-1];
        ht[i]  <= ht[i-1];
      end
    end
  end

  // ---------------- stage 17: floor divide by 3 ----------------
  logic signed [QW:0] t2, av;
  logic signed [15:0] s1, s2;
  assign t2 = sg1[DIV_LAST] ? ~{1'b0, q1[DIV_LAST]} : {1'b0, q1[DIV_LAST]};
  assign av = sg2[DIV_LAST] ? ~{1'b0, q2[DIV_LAST]} : {1'b0, q2[DIV_LAST]};
  assign s1 = 16'(av) + 16'(t2) + 16'(DIV3_OFS);
  assign s2 = $signed({3'b0, qy[DIV_LAST]}) + 16'(t2) + 16'(DIV3_OFS);

  logic [29:0] p1, p2;
  logic        ht17;
  always_ff @(posedge clk) begin
    if (en[17]) begin
      p1   <= s1[14:0] * 15'(DIV3_MUL);
      p2   <= s2[14:0] * 15'(DIV3_MUL);
      ht17 <= ht[DIV_LAST];
    end
  end

  // ---------------- stage 18: offset coords, result register ----------------
  function automatic logic [OUT_W-1:0] sat10(input logic signed [15:0] val);
    if (val < -16'sd512)     sat10 = 10'h200;
    else if (val > 16'sd511) sat10 = 10'h1FF;
    else                     sat10 = val[OUT_W-1:0];
  endfunction

  logic signed [15:0] col_c, qq_c, row_c;
  assign col_c = $signed({2'b0, p1[29:16]}) - 16'(DIV3_OFS / 3);
  assign qq_c  = $signed({2'b0, p2[29:16]}) - 16'(DIV3_OFS / 3) - col_c;
  assign row_c = qq_c + (col_c >>> 1);

  logic                    hit_r;
  logic signed [OUT_W-1:0] row_r, col_r;
  always_ff @(posedge clk) begin
    if (en[18]) begin
      hit_r <= ht17;
      row_r <= ht17 ? sat10(row_c) : '1;
      col_r <= ht17 ? sat10(col_c) : '1;
    end
  end

  assign res.valid   = v[NS];
  assign res.hit     = hit_r;
  assign res.hex_row = row_r;
  assign res.hex_col = col_r;

  // ---------------- checks ----------------
  `P2HG_ASSERT_NOW(a_miss_code, res.valid && !res.hit, res.hex_row == '1 && res.hex_col == '1, "miss without -1,-1")
  `P2HG_ASSERT_NOW(a_hit_col, res.valid && res.hit, res.hex_col >= -10'sd1, "hit with column below -1")
  `P2HG_ASSERT_NEXT(a_enter, pix.valid && pix.ready, v[1], "accepted request not in first stage")
  `P2HG_ASSERT_NEXT(a_hold, v[NS] && !res.ready, v[NS] && $stable(hit_r), "result dropped under stall")

endmodule

// ===== test/tb_pixel_to_hex_grid_coord.sv =====
// Testbench: hex grid lookup checked against an integer predictor, random stimulus and stalls
`timescale 1ns / 1ps
module tb_pixel_to_hex_grid_coord;
  import p2hg_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int LATENCY = 18;

  // Floor division, d > 0
  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp10(longint v);
    if (v < -512) v = -512;
    if (v > 511) v = 511;
    return v[OUT_W-1:0];
  endfunction

  typedef struct packed {
    logic hit;
    logic signed [OUT_W-1:0] hex_row;
    logic signed [OUT_W-1:0] hex_col;
  } hex_result_t;

  // Scoreboard: keeps its own register copy and a queue of pending lookups
  class hex_lookup_board;
    logic [COORD_W-1:0] org_x, org_y;
    logic [RAD_W-1:0] rad, hh;
    logic [CNT_W-1:0] rows_cfg, cols_cfg;
    hex_result_t pending[$];
    int errors;

    function void clear();
      org_x = 0; org_y = 0; rad = 32; hh = 27; rows_cfg = 0; cols_cfg = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ORIGIN_X: org_x = d;
        REG_ORIGIN_Y: org_y = d;
        REG_RADIUS: rad = d[RAD_W-1:0];
        REG_HALF_HGT: hh = d[RAD_W-1:0];
        REG_GRID_ROWS: rows_cfg = d[CNT_W-1:0];
        REG_GRID_COLS: cols_cfg = d[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      longint r, h, nr, nc, w, ht, x, y, den, t2, a, c, q;
      hex_result_t e;
      r = rad; h = hh;
      nr = (rows_cfg > 256) ? 256 : rows_cfg;
      nc = (cols_cfg > 256) ? 256 : cols_cfg;
      w = (nc > 0) ? (r * (3 * nc + 1)) / 2 : 0;
      ht = h * ((nc > 0) ? 1 : 0) + 2 * nr * h;
      x = longint'(px) - longint'(org_x);
      y = longint'(py) - longint'(org_y);
      if (r == 0 || h == 0 || x < 0 || x >= w || y < 0 || y >= ht) begin
        e.hit = 0; e.hex_row = -1; e.hex_col = -1;
      end else begin
        den = 2 * h * r;
        t2 = fdiv((y - h) * r + 2 * h * x, den);
        a = fdiv(2 * h * x - (y - h) * r, den);
        c = fdiv(a + t2, 3);
        q = fdiv(y / h + t2, 3) - c;
        e.hit = 1; e.hex_row = clamp10(q + fdiv(c, 2)); e.hex_col = clamp10(c);
      end
      pending.push_back(e);
    endfunction

    function void check_result(hex_result_t got);
      hex_result_t e;
      if (pending.size() == 0) begin
        $error("result with no pending request");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, got.hit); errors++;
      end
      if (got.hex_row !== e.hex_row) begin
        $error("hex_row: expected %0d actual %0d", e.hex_row, got.hex_row); errors++;
      end
      if (got.hex_col !== e.hex_col) begin
        $error("hex_col: expected %0d actual %0d", e.hex_col, got.hex_col); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  p2hg_in_if pix();
  p2hg_out_if res();

  hex_lookup_board board = new();
  int send_idle_pct = 0;  // sender idle chance, percent
  int recv_stall_pct = 0; // receiver stall chance, percent
  bit hold_off = 0;       // long receiver hold-off request
  longint cycle_count = 0;

  pixel_to_hex_grid_coord uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .pix(pix.sink), .res(res.source)
  );

  always #6 clk = ~clk;

  initial begin
    pix.valid = 0; pix.pixel_x = 0; pix.pixel_y = 0; res.ready = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready)
        board.check_result('{res.hit, res.hex_row, res.hex_col});
      if (hold_off && !hold_done) begin
        hold_left = 200;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res.ready <= 0;
      end else
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    wr_en <= 1; wr_index <= idx; wr_data <= d;
    board.write_reg(idx, d);
    @(posedge clk);
    wr_en <= 0;
  endtask

  // Offer one request; returns at the edge that accepts it, valid still high
  task automatic send_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 0;
      @(posedge clk);
    end
    pix.valid <= 1; pix.pixel_x <= px; pix.pixel_y <= py;
    do @(posedge clk); while (!pix.ready);
    board.note_request(px, py);
  endtask

  task automatic drain();
    pix.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly points in and around the grid box, some anywhere
  task automatic send_random(int n);
    int gw, gh, px, py;
    gw = (board.rad * (3 * board.cols_cfg + 1)) / 2;
    gh = board.hh * (2 * board.rows_cfg + 1);
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        px = board.org_x + $urandom_range(gw + 8) - 4;
        py = board.org_y + $urandom_range(gh + 8) - 4;
      end else begin
        px = $urandom; py = $urandom;
      end
      send_pixel(px[COORD_W-1:0], py[COORD_W-1:0]);
    end
  endtask

  task automatic setup(int ox, int oy, int r, int h, int nr, int nc);
    write_cfg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_cfg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_cfg(REG_RADIUS, CFG_DATA_W'(r));
    write_cfg(REG_HALF_HGT, CFG_DATA_W'(h));
    write_cfg(REG_GRID_ROWS, CFG_DATA_W'(nr));
    write_cfg(REG_GRID_COLS, CFG_DATA_W'(nc));
  endtask

  initial begin
    int r;
    board.clear();
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: reset defaults (empty grid), field extremes
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hAAA, 12'h555);
    drain();
    setup(100, 50, 32, 27, 8, 10);
    send_pixel(100, 50);          // top-left corner sliver
    send_pixel(99, 50);           // just left of box
    send_pixel(100, 49);          // just above
    send_pixel(100 + 496 - 1, 50 + 27 * 17 - 1); // bottom-right inside
    send_pixel(100 + 496, 60);    // just right
    send_pixel(120, 50 + 459);    // just below
    send_pixel(130, 80); send_pixel(160, 100); send_pixel(5, 4000);
    drain();
    // Zero radius / zero half-height: all miss
    setup(0, 0, 0, 27, 5, 5);
    send_pixel(10, 10);
    drain();
    write_cfg(REG_RADIUS, 16); write_cfg(REG_HALF_HGT, 0);
    send_pixel(10, 10);
    drain();
    // Oversized counts, largest shape: row/col saturation
    setup(0, 0, 1, 1, 511, 511);
    send_pixel(383, 512); send_pixel(384, 512); send_pixel(200, 300);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    setup(12'hFFF, 12'hFFF, 1023, 1023, 256, 256);
    send_pixel(12'hFFF, 12'hFFF); send_pixel(0, 0);
    drain();

    // Random phases across idling modes and settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      r = $urandom_range(40, 2);
      if (ph == 11) setup($urandom, $urandom, 1023, 1023, 256, 256);
      else if (ph == 10) setup(0, 0, 1, 1, 256, 256);
      else setup($urandom_range(600), $urandom_range(600), r,
                 (r * 866) / 1000 + $urandom_range(1), $urandom_range(20),
                 $urandom_range(20));
      if (ph == 4) hold_off <= 1;  // block fills up and stalls its input
      send_random(110);
      drain();                     // sender pauses until all results are in
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
